>>> rtl/core/ets_pkg.sv
package ets_pkg;

    localparam int MAX_TASKS = 8;
    localparam int TIME_BITS = 16;

    localparam int IDX_BITS  = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int ACT_BITS  = $clog2(MAX_TASKS + 1);
    localparam int TTD_BITS  = TIME_BITS + 2;

    // fixed field widths of the stream items and the register
    localparam int CFG_BITS       = 4;
    localparam int TASK_IDX_BITS  = 3;
    localparam int EXEC_BITS      = 16;
    localparam int DEADLINE_BITS  = 16;
    localparam int RUN_BITS       = 4;

    localparam int IN_FIELD_BITS  = TASK_IDX_BITS + EXEC_BITS + DEADLINE_BITS;
    localparam int IN_DATA_BITS   = ((IN_FIELD_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_BITS  = ((RUN_BITS + 7) / 8) * 8;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    localparam logic [RUN_BITS-1:0] RUN_IDLE = '0;

    typedef logic [TIME_BITS-1:0]       time_t;
    typedef logic signed [TTD_BITS-1:0] ttd_t;
    typedef logic [IDX_BITS-1:0]        idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_PICK,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic ready;
        logic upd_step;
        logic pick_step;
        logic first;
        logic last;
        logic emit;
        idx_t cnt;
    } ctrl_t;

endpackage

>>> rtl/core/ets_update_unit.sv
module ets_update_unit
    import ets_pkg::*;
(
    input  time_t work_in,
    input  ttd_t  ttd_in,
    input  time_t period_in,
    input  time_t job_in,
    input  logic  pending_in,
    input  logic  run_sel,
    output time_t work_out,
    output ttd_t  ttd_out,
    output logic  pending_out,
    output logic  ran
);

    localparam ttd_t TTD_LOW = {1'b1, {(TTD_BITS-1){1'b0}}};

    ttd_t  period_s;
    time_t work_run;
    ttd_t  ttd_dec;
    ttd_t  ttd_done;
    logic  pend_done;

    assign period_s = $signed({2'b00, period_in});

    always_comb
    begin
        ran      = run_sel && (work_in != '0);
        work_run = ran ? work_in - time_t'(1) : work_in;

        // saturate at the most negative value on overrun
        ttd_dec = (ttd_in != TTD_LOW) ? ttd_in - ttd_t'(1) : ttd_in;

        if (work_run == '0 && pending_in)
        begin
            ttd_done  = ttd_dec + period_s;
            pend_done = 1'b0;
        end
        else
        begin
            ttd_done  = ttd_dec;
            pend_done = pending_in;
        end

        ttd_out = ttd_done;
        if (!pend_done && ttd_done <= period_s)
        begin
            work_out    = job_in;
            pending_out = 1'b1;
        end
        else
        begin
            work_out    = work_run;
            pending_out = pend_done;
        end
    end

endmodule

>>> rtl/core/ets_pick_unit.sv
module ets_pick_unit
    import ets_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  step,
    input  logic  first,
    input  idx_t  idx,
    input  logic  has_work,
    input  ttd_t  ttd,
    input  time_t period,
    output logic  found_next,
    output idx_t  best_next
);

    logic  found_reg;
    idx_t  best_idx_reg;
    ttd_t  best_ttd_reg;
    time_t best_per_reg;

    logic  found_eff;
    logic  take;

    always_comb
    begin
        found_eff = first ? 1'b0 : found_reg;
        // ties go to the larger period, then to the later slot
        take = has_work && (!found_eff || ttd < best_ttd_reg ||
               (ttd == best_ttd_reg && period >= best_per_reg));
        found_next = found_eff || has_work;
        best_next  = take ? idx : best_idx_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else if (step)
        begin
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && take)
        begin
            best_idx_reg <= idx;
            best_ttd_reg <= ttd;
            best_per_reg <= period;
        end
    end

endmodule

>>> rtl/core/ets_seq.sv
module ets_seq
    import ets_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                is_tick,
    input  logic [ACT_BITS-1:0] active,
    input  logic                out_free,
    output ctrl_t               ctrl
);

    state_t state_reg, state_next;
    idx_t   cnt_reg, cnt_next;
    logic   tick_reg, tick_next;
    logic   last;

    assign last = (ACT_BITS'(cnt_reg) == active - ACT_BITS'(1));

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        tick_next  = tick_reg;
        case (state_reg)
            ST_IDLE:
            begin
                cnt_next = '0;
                if (start)
                begin
                    tick_next  = is_tick;
                    state_next = is_tick ? ST_UPDATE : ST_PICK;
                end
            end
            ST_UPDATE:
            begin
                if (last)
                begin
                    cnt_next   = '0;
                    state_next = ST_PICK;
                end
                else
                begin
                    cnt_next = cnt_reg + idx_t'(1);
                end
            end
            ST_PICK:
            begin
                if (last)
                begin
                    cnt_next   = '0;
                    state_next = tick_reg ? ST_EMIT : ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + idx_t'(1);
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctrl           = '0;
        ctrl.cnt       = cnt_reg;
        ctrl.first     = (cnt_reg == '0);
        ctrl.last      = last;
        case (state_reg)
            ST_IDLE:   ctrl.ready     = 1'b1;
            ST_UPDATE: ctrl.upd_step  = 1'b1;
            ST_PICK:   ctrl.pick_step = 1'b1;
            ST_EMIT:   ctrl.emit      = out_free;
            default:   ctrl.ready     = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            tick_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            tick_reg  <= tick_next;
        end
    end

endmodule

>>> rtl/core/edf_tick_scheduler.sv
// a load runs a selection pass; a tick runs an update pass, a selection pass and an emit
// step; each pass walks the active slots one per cycle, each through its own unit
// no new item is accepted until the scheduler is done with the last one
// the result register frees the input side; a tick waits only if a result is still pending
// reset (async, active low) clears work, deadlines, pending flags and the choice to idle,
// sets active_tasks to 1; job lengths and periods hold garbage until loaded
module edf_tick_scheduler
    import ets_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [CFG_BITS-1:0]      cfg_wdata,      // active_tasks
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [IN_DATA_BITS-1:0]  s_tdata,        // task_index, exec_time, rel_deadline
    input  logic [0:0]               s_tuser,        // req_type
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [OUT_DATA_BITS-1:0] m_tdata         // running_task
);

    logic [ACT_BITS-1:0] active_reg;
    logic [RUN_BITS-1:0] chosen_task_reg;
    logic [RUN_BITS-1:0] run_reg;
    logic [RUN_BITS-1:0] out_reg;
    logic                out_valid_reg;

    time_t job_length    [MAX_TASKS];
    time_t period_length [MAX_TASKS];
    time_t work_left     [MAX_TASKS];
    ttd_t  ttd_reg       [MAX_TASKS];
    logic  pending_reg   [MAX_TASKS];

    ctrl_t ctrl;
    logic  s_accept;
    logic  out_free;
    logic  is_load;

    logic [TASK_IDX_BITS-1:0] in_idx;
    time_t in_exec;
    time_t in_period;
    idx_t  load_idx;

    time_t upd_work;
    ttd_t  upd_ttd;
    logic  upd_pending;
    logic  ran;
    logic  run_sel;

    logic  found_next;
    idx_t  best_next;

    assign s_tready = ctrl.ready;
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign is_load  = (s_tuser[0] == REQ_LOAD);

    assign in_idx    = s_tdata[TASK_IDX_BITS-1:0];
    assign in_exec   = TIME_BITS'(s_tdata[TASK_IDX_BITS +: EXEC_BITS]);
    assign in_period = TIME_BITS'(s_tdata[TASK_IDX_BITS+EXEC_BITS +: DEADLINE_BITS]);
    assign load_idx  = IDX_BITS'(in_idx);

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_DATA_BITS'(out_reg);

    assign run_sel = (chosen_task_reg != RUN_IDLE) &&
                     (RUN_BITS'(ctrl.cnt) == chosen_task_reg - RUN_BITS'(1));

    ets_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (s_accept),
        .is_tick  (s_tuser[0] == REQ_TICK),
        .active   (active_reg),
        .out_free (out_free),
        .ctrl     (ctrl)
    );

    ets_update_unit u_update (
        .work_in     (work_left[ctrl.cnt]),
        .ttd_in      (ttd_reg[ctrl.cnt]),
        .period_in   (period_length[ctrl.cnt]),
        .job_in      (job_length[ctrl.cnt]),
        .pending_in  (pending_reg[ctrl.cnt]),
        .run_sel     (run_sel),
        .work_out    (upd_work),
        .ttd_out     (upd_ttd),
        .pending_out (upd_pending),
        .ran         (ran)
    );

    ets_pick_unit u_pick (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (ctrl.pick_step),
        .first      (ctrl.first),
        .idx        (ctrl.cnt),
        .has_work   (work_left[ctrl.cnt] != '0),
        .ttd        (ttd_reg[ctrl.cnt]),
        .period     (period_length[ctrl.cnt]),
        .found_next (found_next),
        .best_next  (best_next)
    );

    // active_tasks, clamped to 1..MAX_TASKS
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= ACT_BITS'(1);
        end
        else if (cfg_we)
        begin
            if (cfg_wdata == '0)
                active_reg <= ACT_BITS'(1);
            else if (int'(cfg_wdata) > MAX_TASKS)
                active_reg <= ACT_BITS'(MAX_TASKS);
            else
                active_reg <= ACT_BITS'(cfg_wdata);
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept && is_load && int'(in_idx) < MAX_TASKS)
        begin
            job_length[load_idx]    <= in_exec;
            period_length[load_idx] <= in_period;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_TASKS; i++)
            begin
                work_left[i]   <= '0;
                ttd_reg[i]     <= '0;
                pending_reg[i] <= 1'b0;
            end
        end
        else if (s_accept && is_load && int'(in_idx) < MAX_TASKS)
        begin
            work_left[load_idx]   <= in_exec;
            ttd_reg[load_idx]     <= $signed({2'b00, in_period});
            pending_reg[load_idx] <= 1'b1;
        end
        else if (ctrl.upd_step)
        begin
            work_left[ctrl.cnt]   <= upd_work;
            ttd_reg[ctrl.cnt]     <= upd_ttd;
            pending_reg[ctrl.cnt] <= upd_pending;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chosen_task_reg <= RUN_IDLE;
            run_reg         <= RUN_IDLE;
        end
        else
        begin
            if (s_accept)
                run_reg <= RUN_IDLE;
            else if (ctrl.upd_step && ran)
                run_reg <= RUN_BITS'(ctrl.cnt) + RUN_BITS'(1);

            if (ctrl.pick_step && ctrl.last)
                chosen_task_reg <= found_next ? RUN_BITS'(best_next) + RUN_BITS'(1)
                                              : RUN_IDLE;
        end
    end

    // result register, refilled on the same edge the old result transfers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.emit)
            out_reg <= run_reg;
    end

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_accept |=> !s_tready)
        else $error("scheduler took an item while still working");

    a_single_run: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.upd_step && ran) |-> (run_reg == RUN_IDLE))
        else $error("more than one slot ran in one tick");

    a_choice_range: assert property (@(posedge clk) disable iff (!rst_n)
        int'(chosen_task_reg) <= MAX_TASKS)
        else $error("chosen task beyond the slot count");

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.emit |-> (!$past(ctrl.ready) && !s_tready))
        else $error("result emitted outside a tick");

endmodule
